// File: sv/bsoc_pkg.sv
// Package for the battery state-of-charge curve interpolator.
// Holds the 21-point discharge curve, segment spans and reciprocals.
// Standalone; used by battery_soc_curve_interpolator.
package bsoc_pkg;

	localparam int MvW     = 13;
	localparam int ChW     = 14;
	localparam int Points  = 21;
	localparam int IdxW    = 5;
	localparam int OffW    = 7;
	localparam int SpanChW = 10;
	localparam int ProdW   = 16;
	localparam int RecipW  = 20;
	localparam int RecipSh = 24;
	localparam int ScaledW = ProdW + RecipW;

	localparam logic [IdxW-1:0] LastIdx = IdxW'(Points - 1);
	localparam logic [ChW-1:0]  MaxCharge = ChW'(10000);

	typedef logic [IdxW-1:0] idx_t;

	function automatic logic [MvW-1:0] curve_mv(input idx_t idx);
		logic [MvW-1:0] mv;
		case (idx)
			5'd0:  mv = 13'd4200;
			5'd1:  mv = 13'd4150;
			5'd2:  mv = 13'd4100;
			5'd3:  mv = 13'd4050;
			5'd4:  mv = 13'd4000;
			5'd5:  mv = 13'd3950;
			5'd6:  mv = 13'd3900;
			5'd7:  mv = 13'd3850;
			5'd8:  mv = 13'd3800;
			5'd9:  mv = 13'd3780;
			5'd10: mv = 13'd3750;
			5'd11: mv = 13'd3720;
			5'd12: mv = 13'd3700;
			5'd13: mv = 13'd3650;
			5'd14: mv = 13'd3600;
			5'd15: mv = 13'd3550;
			5'd16: mv = 13'd3500;
			5'd17: mv = 13'd3450;
			5'd18: mv = 13'd3400;
			5'd19: mv = 13'd3300;
			5'd20: mv = 13'd3200;
			default: mv = 13'd3200;
		endcase
		return mv;
	endfunction

	function automatic logic [ChW-1:0] curve_charge(input idx_t idx);
		logic [ChW-1:0] ch;
		case (idx)
			5'd0:  ch = 14'd10000;
			5'd1:  ch = 14'd9500;
			5'd2:  ch = 14'd9000;
			5'd3:  ch = 14'd8500;
			5'd4:  ch = 14'd8000;
			5'd5:  ch = 14'd7500;
			5'd6:  ch = 14'd6800;
			5'd7:  ch = 14'd6000;
			5'd8:  ch = 14'd5200;
			5'd9:  ch = 14'd4500;
			5'd10: ch = 14'd3800;
			5'd11: ch = 14'd3200;
			5'd12: ch = 14'd2600;
			5'd13: ch = 14'd2000;
			5'd14: ch = 14'd1500;
			5'd15: ch = 14'd1000;
			5'd16: ch = 14'd700;
			5'd17: ch = 14'd500;
			5'd18: ch = 14'd300;
			5'd19: ch = 14'd100;
			5'd20: ch = 14'd0;
			default: ch = 14'd0;
		endcase
		return ch;
	endfunction

	// charge rise from point idx up to point idx-1; zero for the top point
	function automatic logic [SpanChW-1:0] span_ch(input idx_t idx);
		logic [SpanChW-1:0] s;
		case (idx)
			5'd6:  s = 10'd700;
			5'd7:  s = 10'd800;
			5'd8:  s = 10'd800;
			5'd9:  s = 10'd700;
			5'd10: s = 10'd700;
			5'd11: s = 10'd600;
			5'd12: s = 10'd600;
			5'd13: s = 10'd600;
			5'd14: s = 10'd500;
			5'd15: s = 10'd500;
			5'd16: s = 10'd300;
			5'd17: s = 10'd200;
			5'd18: s = 10'd200;
			5'd19: s = 10'd200;
			5'd20: s = 10'd100;
			5'd1, 5'd2, 5'd3, 5'd4, 5'd5: s = 10'd500;
			default: s = 10'd0;
		endcase
		return s;
	endfunction

	// ceil(2^24 / span_mv); exact floor for products below 2^16
	function automatic logic [RecipW-1:0] span_recip(input idx_t idx);
		logic [RecipW-1:0] r;
		case (idx)
			5'd9, 5'd12:  r = 20'd838861;   // 20 mV
			5'd10, 5'd11: r = 20'd559241;   // 30 mV
			5'd19, 5'd20: r = 20'd167773;   // 100 mV
			default:      r = 20'd335545;   // 50 mV
		endcase
		return r;
	endfunction

endpackage

// File: sv/battery_soc_curve_interpolator.sv
// Battery voltage to state-of-charge interpolator, four-stage pipeline.
// Depends on bsoc_pkg for the curve constants and reciprocal tables.
//
// Takes one voltage item per cycle while in_ready is high; output back-pressure
// stalls it. Each charge passes the stage 1 to 4 registers. Stage 1 picks the
// curve segment with twenty-one parallel compares and forms the offset, stage 2
// multiplies offset by charge span, stage 3 divides by the voltage span through
// a reciprocal multiply, stage 4 adds the segment base and holds the result.
// Each stage moves when its successor is empty or moving, so bubbles close up
// under output back-pressure.
module battery_soc_curve_interpolator (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [bsoc_pkg::MvW-1:0] battery_millivolts,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [bsoc_pkg::ChW-1:0] charge_hundredths
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	bsoc_pkg::idx_t                  seg_s1, seg_s2, seg_s3;
	logic [bsoc_pkg::OffW-1:0]       off_s1;
	logic [bsoc_pkg::ProdW-1:0]      prod_s2;
	logic [bsoc_pkg::ScaledW-1:0]    scaled_s3;
	logic [bsoc_pkg::ChW-1:0]        charge_s4;

	bsoc_pkg::idx_t          seg_c;
	logic [bsoc_pkg::MvW-1:0] diff_c;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// first point from the top not above the voltage
	always_comb begin
		seg_c = bsoc_pkg::LastIdx;
		for (int k = bsoc_pkg::Points - 1; k >= 1; k--) begin
			if (battery_millivolts >= bsoc_pkg::curve_mv(bsoc_pkg::IdxW'(k)))
				seg_c = bsoc_pkg::IdxW'(k);
		end
		if (battery_millivolts >= bsoc_pkg::curve_mv('0))
			seg_c = '0;
		if (seg_c == '0 || seg_c == bsoc_pkg::LastIdx && battery_millivolts <=
				bsoc_pkg::curve_mv(bsoc_pkg::LastIdx))
			diff_c = '0;
		else
			diff_c = battery_millivolts - bsoc_pkg::curve_mv(seg_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			seg_s1 <= seg_c;
			off_s1 <= diff_c[bsoc_pkg::OffW-1:0];
		end
		if (en_s2 && v_s1) begin
			seg_s2  <= seg_s1;
			prod_s2 <= bsoc_pkg::ProdW'(off_s1 * bsoc_pkg::span_ch(seg_s1));
		end
		if (en_s3 && v_s2) begin
			seg_s3    <= seg_s2;
			scaled_s3 <= bsoc_pkg::ScaledW'(prod_s2 * bsoc_pkg::span_recip(seg_s2));
		end
		if (en_s4 && v_s3) begin
			charge_s4 <= bsoc_pkg::curve_charge(seg_s3) +
				bsoc_pkg::ChW'(scaled_s3[bsoc_pkg::ScaledW-1:bsoc_pkg::RecipSh]);
		end
	end

	assign out_valid         = v_s4;
	assign charge_hundredths = charge_s4;

	a_charge_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> charge_s4 <= bsoc_pkg::MaxCharge)
		else $error("charge above full scale");

	a_top_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && seg_s1 == '0 |-> off_s1 == '0)
		else $error("top segment with nonzero offset");

	a_offset_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && seg_s1 != '0 |->
		7'(off_s1) < 7'(bsoc_pkg::curve_mv(seg_s1 - 5'd1) - bsoc_pkg::curve_mv(seg_s1)))
		else $error("offset outside its segment");

	a_stage_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && en_s4 |=> v_s4)
		else $error("item lost between stage 3 and output");

endmodule
